[rtl/tpgc_pkg.sv]
package tpgc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  // event codes
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_TAP   = 3'd1;
  localparam logic [2:0] ACT_MENU  = 3'd2;
  localparam logic [2:0] ACT_READY = 3'd3;
  localparam logic [2:0] ACT_RESET = 3'd4;

  // game phases
  localparam logic [1:0] PH_ARMED    = 2'd0;
  localparam logic [1:0] PH_RUNNING  = 2'd1;
  localparam logic [1:0] PH_PAUSED   = 2'd2;
  localparam logic [1:0] PH_FINISHED = 2'd3;

  // time control modes
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_INCR    = 3'd1;
  localparam logic [2:0] MODE_DELAY   = 3'd2;
  localparam logic [2:0] MODE_CAPPED  = 3'd3;
  localparam logic [2:0] MODE_LIMITED = 3'd4;
  localparam logic [2:0] MODE_BYOYOMI = 3'd5;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_P1_START = 3'd0;
  localparam logic [2:0] REG_P1_MODE  = 3'd1;
  localparam logic [2:0] REG_P1_BONUS = 3'd2;
  localparam logic [2:0] REG_P2_START = 3'd3;
  localparam logic [2:0] REG_P2_MODE  = 3'd4;
  localparam logic [2:0] REG_P2_BONUS = 3'd5;
  localparam logic [2:0] REG_TICK     = 3'd6;

  localparam logic [31:0] START_RST = 32'd300000;
  localparam logic [31:0] BONUS_RST = 32'd0;
  localparam logic [2:0]  MODE_RST  = MODE_NONE;
  localparam logic [9:0]  TICK_RST  = 10'd100;

endpackage

[rtl/two_player_game_clock.sv]
// Two-player game clock.
// Input channel (in_valid/in_stall, action, player) carries one event per
// transaction: tick, tap, menu entry, ready or reset. Output channel
// (out_valid/out_stall plus the result fields) returns exactly one result per
// event: the clock state after the event, and alarm_start when that event
// finished the game.
// Two register stages, event register then result register: an event is
// captured in the event register and its result then in the result
// register. The state update is a single combinational pass, so one event
// is taken every cycle while the receiver does not stall.
// A stalled result is held in the result register while the next event waits
// in the event register; in_stall rises only when both are full and the
// receiver stalls. Timing registers are written over the APB port (byte
// addresses 0x00 to 0x18) by the user only while no event is in flight; the
// block does not enforce it. Reads return the stored values.
// Reset (rst, synchronous) empties both stages, restores the registers to
// their defaults and arms the clock with the default times.
module two_player_game_clock #(
  parameter int TIME_WIDTH = tpgc_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpgc_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpgc_pkg::DATA_W-1:0]   pwdata,
  output logic [tpgc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // events
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    action,
  input  logic                          player,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    phase,
  output logic                          to_move,
  output logic [31:0]                   p1_time_ms,
  output logic [31:0]                   p1_bonus_left_ms,
  output logic [31:0]                   p2_time_ms,
  output logic [31:0]                   p2_bonus_left_ms,
  output logic                          p1_in_menu,
  output logic                          p2_in_menu,
  output logic                          p1_lost,
  output logic                          p2_lost,
  output logic                          alarm_start
);

  localparam int TW = TIME_WIDTH;
  // wide enough for any 32-bit setting plus any time value, with a carry
  localparam int CW = ((TW > 32) ? TW : 32) + 1;
  localparam logic [TW-1:0] TMAX = '1;

  function automatic logic [TW-1:0] clamp_t(input logic [31:0] v);
    logic [CW-1:0] x;
    x = CW'(v);
    return (x > CW'(TMAX)) ? TMAX : x[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] dec_sat(input logic [TW-1:0] v, input logic [9:0] d);
    logic [TW-1:0] dx;
    dx = TW'(d);
    return (v >= dx) ? v - dx : '0;
  endfunction

  function automatic logic [TW-1:0] add_sat(input logic [TW-1:0] a, input logic [31:0] b);
    logic [CW-1:0] s;
    s = CW'(a) + CW'(b);
    return (s > CW'(TMAX)) ? TMAX : s[TW-1:0];
  endfunction

  function automatic logic [31:0] to32(input logic [TW-1:0] v);
    logic [CW-1:0] x;
    x = CW'(v);
    return x[31:0];
  endfunction

  // ---------------- configuration registers ----------------
  logic [31:0] cfg_start [2];
  logic [2:0]  cfg_mode  [2];
  logic [31:0] cfg_bonus [2];
  logic [9:0]  cfg_tick;
  logic [2:0]  reg_index;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_start[0] <= tpgc_pkg::START_RST;
      cfg_start[1] <= tpgc_pkg::START_RST;
      cfg_mode[0]  <= tpgc_pkg::MODE_RST;
      cfg_mode[1]  <= tpgc_pkg::MODE_RST;
      cfg_bonus[0] <= tpgc_pkg::BONUS_RST;
      cfg_bonus[1] <= tpgc_pkg::BONUS_RST;
      cfg_tick     <= tpgc_pkg::TICK_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        tpgc_pkg::REG_P1_START: cfg_start[0] <= pwdata;
        tpgc_pkg::REG_P1_MODE:  cfg_mode[0]  <= pwdata[2:0];
        tpgc_pkg::REG_P1_BONUS: cfg_bonus[0] <= pwdata;
        tpgc_pkg::REG_P2_START: cfg_start[1] <= pwdata;
        tpgc_pkg::REG_P2_MODE:  cfg_mode[1]  <= pwdata[2:0];
        tpgc_pkg::REG_P2_BONUS: cfg_bonus[1] <= pwdata;
        tpgc_pkg::REG_TICK:     cfg_tick     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      tpgc_pkg::REG_P1_START: prdata = cfg_start[0];
      tpgc_pkg::REG_P1_MODE:  prdata = 32'(cfg_mode[0]);
      tpgc_pkg::REG_P1_BONUS: prdata = cfg_bonus[0];
      tpgc_pkg::REG_P2_START: prdata = cfg_start[1];
      tpgc_pkg::REG_P2_MODE:  prdata = 32'(cfg_mode[1]);
      tpgc_pkg::REG_P2_BONUS: prdata = cfg_bonus[1];
      tpgc_pkg::REG_TICK:     prdata = 32'(cfg_tick);
      default:                prdata = '0;
    endcase
  end

  // ---------------- event register ----------------
  logic       s1_valid;
  logic [2:0] action_q;
  logic       player_q;
  logic       out_hold;
  logic       s1_adv;

  assign out_hold = out_valid && out_stall;
  assign in_stall = s1_valid && out_hold;
  assign s1_adv   = s1_valid && !out_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      action_q <= action;
      player_q <= player;
    end
  end

  // ---------------- clock state ----------------
  logic [1:0]    game_phase,     game_phase_next;
  logic          running_player, running_player_next;
  logic [TW-1:0] main_left [2],  main_left_next [2];
  logic [TW-1:0] bonus_left [2], bonus_left_next [2];
  logic [1:0]    menu_flags,     menu_flags_next;
  logic [1:0]    loser_flags,    loser_flags_next;
  logic          alarm_next;

  logic          sel;
  logic [2:0]    sel_mode;
  logic [TW-1:0] tm, tb;
  logic          lost;

  assign sel      = (action_q == tpgc_pkg::ACT_TICK) ? running_player : player_q;
  assign sel_mode = cfg_mode[sel];

  always_comb begin
    game_phase_next     = game_phase;
    running_player_next = running_player;
    main_left_next      = main_left;
    bonus_left_next     = bonus_left;
    menu_flags_next     = menu_flags;
    loser_flags_next    = loser_flags;
    alarm_next          = 1'b0;
    tm                  = main_left[sel];
    tb                  = bonus_left[sel];
    lost                = 1'b0;

    unique case (action_q)
      tpgc_pkg::ACT_TICK: begin
        if (game_phase == tpgc_pkg::PH_RUNNING) begin
          unique case (sel_mode)
            tpgc_pkg::MODE_NONE, tpgc_pkg::MODE_INCR, tpgc_pkg::MODE_CAPPED: begin
              tm = dec_sat(tm, cfg_tick);
            end
            tpgc_pkg::MODE_DELAY: begin
              // delay runs off first, main time only once it is spent
              if (tb >= TW'(cfg_tick)) begin
                tb = tb - TW'(cfg_tick);
              end else begin
                tb = '0;
                tm = dec_sat(tm, cfg_tick);
              end
            end
            tpgc_pkg::MODE_LIMITED: begin
              tb = dec_sat(tb, cfg_tick);
              tm = dec_sat(tm, cfg_tick);
            end
            tpgc_pkg::MODE_BYOYOMI: begin
              if (tm >= TW'(cfg_tick)) begin
                tm = tm - TW'(cfg_tick);
              end else begin
                tm = '0;
                tb = dec_sat(tb, cfg_tick);
              end
            end
            default: ;
          endcase
          if (sel_mode == tpgc_pkg::MODE_LIMITED && tb == '0) begin
            lost = 1'b1;
          end else if (sel_mode == tpgc_pkg::MODE_BYOYOMI) begin
            lost = (tm == '0) && (tb == '0);
          end else begin
            lost = (tm == '0);
          end
          main_left_next[sel]  = tm;
          bonus_left_next[sel] = tb;
          if (lost) begin
            game_phase_next       = tpgc_pkg::PH_FINISHED;
            loser_flags_next[sel] = 1'b1;
            alarm_next            = 1'b1;
          end
        end
      end

      tpgc_pkg::ACT_TAP: begin
        unique case (game_phase)
          tpgc_pkg::PH_ARMED, tpgc_pkg::PH_PAUSED: begin
            if (menu_flags == 2'b00) begin
              if (game_phase == tpgc_pkg::PH_ARMED) begin
                for (int i = 0; i < 2; i++) begin
                  main_left_next[i]  = clamp_t(cfg_start[i]);
                  bonus_left_next[i] = clamp_t(cfg_bonus[i]);
                end
              end
              game_phase_next     = tpgc_pkg::PH_RUNNING;
              running_player_next = ~sel;
            end
          end
          tpgc_pkg::PH_RUNNING: begin
            if (sel == running_player) begin
              unique case (sel_mode)
                tpgc_pkg::MODE_INCR: tm = add_sat(tm, cfg_bonus[sel]);
                tpgc_pkg::MODE_DELAY, tpgc_pkg::MODE_LIMITED: tb = clamp_t(cfg_bonus[sel]);
                tpgc_pkg::MODE_CAPPED: begin
                  tm = add_sat(tm, cfg_bonus[sel]);
                  if (CW'(tm) > CW'(cfg_start[sel])) begin
                    tm = TW'(cfg_start[sel]);
                  end
                end
                tpgc_pkg::MODE_BYOYOMI: begin
                  // period refills only once main time is gone
                  if (tm == '0) begin
                    tb = clamp_t(cfg_bonus[sel]);
                  end
                end
                default: ;
              endcase
              main_left_next[sel]  = tm;
              bonus_left_next[sel] = tb;
              running_player_next  = ~sel;
            end
          end
          default: begin
            game_phase_next  = tpgc_pkg::PH_ARMED;
            menu_flags_next  = 2'b00;
            loser_flags_next = 2'b00;
            for (int i = 0; i < 2; i++) begin
              main_left_next[i]  = clamp_t(cfg_start[i]);
              bonus_left_next[i] = clamp_t(cfg_bonus[i]);
            end
          end
        endcase
      end

      tpgc_pkg::ACT_MENU: begin
        if (!menu_flags[sel]) begin
          if (game_phase == tpgc_pkg::PH_RUNNING) begin
            game_phase_next = tpgc_pkg::PH_PAUSED;
          end else if (game_phase == tpgc_pkg::PH_FINISHED) begin
            game_phase_next  = tpgc_pkg::PH_ARMED;
            menu_flags_next  = 2'b00;
            loser_flags_next = 2'b00;
            for (int i = 0; i < 2; i++) begin
              main_left_next[i]  = clamp_t(cfg_start[i]);
              bonus_left_next[i] = clamp_t(cfg_bonus[i]);
            end
          end
          menu_flags_next[sel] = 1'b1;
        end
      end

      tpgc_pkg::ACT_READY: begin
        menu_flags_next[sel] = 1'b0;
      end

      tpgc_pkg::ACT_RESET: begin
        game_phase_next  = tpgc_pkg::PH_ARMED;
        menu_flags_next  = 2'b00;
        loser_flags_next = 2'b00;
        for (int i = 0; i < 2; i++) begin
          main_left_next[i]  = clamp_t(cfg_start[i]);
          bonus_left_next[i] = clamp_t(cfg_bonus[i]);
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      game_phase     <= tpgc_pkg::PH_ARMED;
      running_player <= 1'b0;
      main_left[0]   <= clamp_t(tpgc_pkg::START_RST);
      main_left[1]   <= clamp_t(tpgc_pkg::START_RST);
      bonus_left[0]  <= clamp_t(tpgc_pkg::BONUS_RST);
      bonus_left[1]  <= clamp_t(tpgc_pkg::BONUS_RST);
      menu_flags     <= 2'b00;
      loser_flags    <= 2'b00;
    end else if (s1_adv) begin
      game_phase     <= game_phase_next;
      running_player <= running_player_next;
      main_left      <= main_left_next;
      bonus_left     <= bonus_left_next;
      menu_flags     <= menu_flags_next;
      loser_flags    <= loser_flags_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_hold) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      phase            <= game_phase_next;
      to_move          <= running_player_next;
      p1_time_ms       <= to32(main_left_next[0]);
      p1_bonus_left_ms <= to32(bonus_left_next[0]);
      p2_time_ms       <= to32(main_left_next[1]);
      p2_bonus_left_ms <= to32(bonus_left_next[1]);
      p1_in_menu       <= menu_flags_next[0];
      p2_in_menu       <= menu_flags_next[1];
      p1_lost          <= loser_flags_next[0];
      p2_lost          <= loser_flags_next[1];
      alarm_start      <= alarm_next;
    end
  end

`ifndef SYNTH
  // an event leaving the event register always lands as a result
  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("event advanced but no result followed");

  a_alarm_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alarm_start) |-> (phase == tpgc_pkg::PH_FINISHED && (p1_lost || p2_lost)))
    else $error("alarm without finished phase and loser");

  a_one_loser: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(p1_lost && p2_lost))
    else $error("both players marked as loser");
`endif

endmodule
